>>> hw/rtl/spss_pkg.sv
package spss_pkg;

  localparam int HDR_LEN  = 32;
  localparam int NAME_LEN = 9;
  localparam int SIG_LEN  = 68;
  localparam int HIST_LEN = SIG_LEN - 1;
  localparam int SEEN_W   = 7;

  // byte k (from the LSB) is the pattern byte expected k beats before the newest
  localparam logic [HDR_LEN*8-1:0]  HDR_PAT  = "Content-Disposition: attachment;";
  localparam logic [NAME_LEN*8-1:0] NAME_PAT = "eicar.com";
  localparam logic [SIG_LEN*8-1:0]  SIG_PAT  =
    "X5O!P%@AP[4\\PZX54(P^)7CC)7}$EICAR-STANDARD-ANTIVIRUS-TEST-FILE!$H+H*";

  // leading four bytes of command packets
  localparam logic [31:0] LEAD_EHLO = 32'h45484C4F;
  localparam logic [31:0] LEAD_MAIL = 32'h4D41494C;
  localparam logic [31:0] LEAD_RCPT = 32'h52435054;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_EHLO  = 2'd1;
  localparam logic [1:0] KIND_MAIL  = 2'd2;
  localparam logic [1:0] KIND_RCPT  = 2'd3;

  localparam logic [1:0] STAGE_NONE = 2'd0;
  localparam logic [1:0] STAGE_HDR  = 2'd1;
  localparam logic [1:0] STAGE_NAME = 2'd2;
  localparam logic [1:0] STAGE_SIG  = 2'd3;

  localparam logic [2:0] REG_SCAN_ENABLE = 3'd0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] command_kind;
    logic [1:0] stage_reached;
    logic       virus_found;
  } out_beat_t;

  typedef struct packed {
    logic hdr;
    logic name;
    logic sig;
  } hits_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= "A" && c <= "Z") begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/spss_stream_if.sv
interface spss_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/spss_match.sv
module spss_match
  import spss_pkg::*;
(
  input  logic [SIG_LEN*8-1:0] window,   // byte 0 newest
  output hits_t                hits
);

  logic [NAME_LEN*8-1:0] name_fold;

  always_comb begin
    for (int k = 0; k < NAME_LEN; k++) begin
      name_fold[8*k +: 8] = fold_case(window[8*k +: 8]);
    end
  end

  // pattern is already lower case
  assign hits.hdr  = (window[HDR_LEN*8-1:0] == HDR_PAT);
  assign hits.name = (name_fold == NAME_PAT);
  assign hits.sig  = (window == SIG_PAT);

endmodule

>>> hw/rtl/staged_payload_signature_scan_core.sv
// Channel | Dir | Beat fields                                 | Handshake
// in_bus  | in  | data_byte[7:0], first_byte, last_byte       | valid/ready
// out_bus | out | command_kind[1:0], stage_reached[1:0], virus_found | valid/ready
// APB cfg | in  | paddr[2:0], pwdata[31:0] (scan_enable @ 0)  | psel/penable, pready=1
//
// One byte per cycle sustained: input register -> window compare -> result register.
// A last byte's result is loaded into the result register when that byte leaves the input register.
// A byte without last mark never waits on out_bus; a last byte holds the input
// register only while a previous result is still unread.
// Reset (rst_n, sync, low) clears scan_enable, both valid flags and the packet state but the byte history.
module staged_payload_signature_scan_core
  import spss_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  spss_stream_if.sink        in_bus,
  spss_stream_if.source      out_bus,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // ---------------- configuration ----------------
  logic scan_enable_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && ({paddr[2], 2'b00} == REG_SCAN_ENABLE);
  assign prdata = ({paddr[2], 2'b00} == REG_SCAN_ENABLE) ? {31'd0, scan_enable_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_enable_r <= 1'b0;
    end else if (cfg_wr) begin
      scan_enable_r <= pwdata[0];
    end
  end

  // ---------------- input register ----------------
  logic     s1_valid_r;
  in_beat_t s1_beat_r;
  logic     out_free;
  logic     s1_fire;
  logic     in_take;

  assign out_free     = !out_bus.valid || out_bus.ready;
  // only a reporting beat needs the result slot
  assign s1_fire      = s1_valid_r && (!s1_beat_r.last_byte || out_free);
  assign in_bus.ready = !s1_valid_r || s1_fire;
  assign in_take      = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_beat_r <= in_bus.payload;
    end
  end

  // ---------------- packet state ----------------
  logic [HIST_LEN*8-1:0] hist_r;      // byte 0 = previous beat; masked by seen count
  logic [1:0]            stage_r;
  logic [SEEN_W-1:0]     seen_r;
  logic [31:0]           lead_r;
  logic                  stopped_r;

  logic [HIST_LEN*8-1:0] hist_nxt;
  logic [1:0]            stage_nxt;
  logic [SEEN_W-1:0]     seen_nxt;
  logic [31:0]           lead_nxt;
  logic                  stopped_nxt;

  // first mark restarts the packet before this byte is used
  logic [1:0]        eff_stage;
  logic [SEEN_W-1:0] eff_seen;
  logic [31:0]       eff_lead;
  logic              eff_stopped;
  logic [7:0]        cur;

  logic [1:0]        stage_upd;
  logic [SEEN_W-1:0] seen_upd;
  logic [31:0]       lead_upd;
  logic              stopped_upd;

  hits_t     hits;
  out_beat_t res;

  assign cur         = s1_beat_r.data_byte;
  assign eff_stage   = s1_beat_r.first_byte ? STAGE_NONE : stage_r;
  assign eff_seen    = s1_beat_r.first_byte ? '0 : seen_r;
  assign eff_lead    = s1_beat_r.first_byte ? 32'd0 : lead_r;
  assign eff_stopped = s1_beat_r.first_byte ? 1'b0 : stopped_r;

  spss_match u_match (
    .window ({hist_r, cur}),
    .hits   (hits)
  );

  always_comb begin
    stage_upd   = eff_stage;
    stopped_upd = eff_stopped;
    lead_upd    = (eff_seen < SEEN_W'(4)) ? {eff_lead[23:0], cur} : eff_lead;
    seen_upd    = (eff_seen < SEEN_W'(SIG_LEN)) ? eff_seen + SEEN_W'(1) : eff_seen;

    if (!eff_stopped) begin
      if (cur == 8'd0) begin
        stopped_upd = 1'b1;
      end else begin
        case (eff_stage)
          STAGE_NONE: begin
            if (hits.hdr && eff_seen >= SEEN_W'(HDR_LEN - 1)) stage_upd = STAGE_HDR;
          end
          STAGE_HDR: begin
            if (hits.name && eff_seen >= SEEN_W'(NAME_LEN - 1)) stage_upd = STAGE_NAME;
          end
          STAGE_NAME: begin
            if (hits.sig && eff_seen >= SEEN_W'(SIG_LEN - 1)) begin
              stage_upd   = STAGE_SIG;
              stopped_upd = 1'b1;
            end
          end
          default: begin
            stage_upd = eff_stage;
          end
        endcase
      end
    end

    // report
    res.command_kind  = KIND_OTHER;
    res.stage_reached = STAGE_NONE;
    if (scan_enable_r) begin
      if (seen_upd >= SEEN_W'(4)) begin
        if (lead_upd == LEAD_EHLO)      res.command_kind = KIND_EHLO;
        else if (lead_upd == LEAD_MAIL) res.command_kind = KIND_MAIL;
        else if (lead_upd == LEAD_RCPT) res.command_kind = KIND_RCPT;
      end
      if (res.command_kind == KIND_OTHER) res.stage_reached = stage_upd;
    end
    res.virus_found = (res.stage_reached == STAGE_SIG);

    // last byte closes the packet
    hist_nxt = {hist_r[(HIST_LEN-1)*8-1:0], cur};
    if (s1_beat_r.last_byte) begin
      stage_nxt   = STAGE_NONE;
      seen_nxt    = '0;
      lead_nxt    = 32'd0;
      stopped_nxt = 1'b0;
    end else begin
      stage_nxt   = stage_upd;
      seen_nxt    = seen_upd;
      lead_nxt    = lead_upd;
      stopped_nxt = stopped_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r   <= STAGE_NONE;
      seen_r    <= '0;
      lead_r    <= 32'd0;
      stopped_r <= 1'b0;
    end else if (s1_fire) begin
      stage_r   <= stage_nxt;
      seen_r    <= seen_nxt;
      lead_r    <= lead_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      hist_r <= hist_nxt;
    end
  end

  // ---------------- result register ----------------
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_beat_t out_beat_r;
  logic      res_load;

  assign res_load = s1_fire && s1_beat_r.last_byte;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_beat_r <= res;
    end
  end

  assign out_bus.valid   = out_valid_r;
  assign out_bus.payload = out_beat_r;

endmodule

>>> dv/staged_payload_signature_scan_core_tb.sv
module staged_payload_signature_scan_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spss_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int MAX_GAP     = 10;
  // Idle margin after the queues empty; covers the byte pipeline draining.
  localparam int SETTLE      = 6;
  localparam int CYCLE_LIMIT = 600000;

  // One queued input beat; drain holds it back until every report has come out.
  typedef struct {
    in_beat_t beat;
    bit       drain;
  } pend_beat_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #CLK_HALF clk = ~clk;

  spss_stream_if #(.payload_t(in_beat_t))  in_if  ();
  spss_stream_if #(.payload_t(out_beat_t)) out_if ();

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  staged_payload_signature_scan_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // Scanner prediction state. Mirrors what the core keeps per packet: a window
  // of earlier bytes (newest at index 0), the stage reached, a saturating byte
  // count, the first four bytes and the halt flag (zero byte or full hit).
  // ---------------------------------------------------------------------------
  logic        scan_on = 1'b0;
  logic [7:0]  byte_hist [HIST_LEN];
  logic [1:0]  stage_hit;
  logic [6:0]  pkt_len;
  logic [31:0] head_word;
  logic        halted;

  out_beat_t   report_q [$];   // reports owed by the core, oldest first
  pend_beat_t  tx_q [$];       // beats waiting for the driver

  int tx_gap;
  int rx_stall;
  int rx_next;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int errors  = 0;
  int cycles  = 0;
  int queued_bytes = 0;

  task automatic restart_packet();
    foreach (byte_hist[i]) byte_hist[i] = 8'h00;
    stage_hit = STAGE_NONE;
    pkt_len   = '0;
    head_word = '0;
    halted    = 1'b0;
  endtask

  function automatic int pat_len(input logic [1:0] which);
    case (which)
      STAGE_HDR:  return HDR_LEN;
      STAGE_NAME: return NAME_LEN;
      default:    return SIG_LEN;
    endcase
  endfunction

  // k counts back from the final pattern character (k = 0 is the last one).
  function automatic logic [7:0] pat_from_end(input logic [1:0] which, input int k);
    case (which)
      STAGE_HDR:  return HDR_PAT[8*k +: 8];
      STAGE_NAME: return NAME_PAT[8*k +: 8];
      default:    return SIG_PAT[8*k +: 8];
    endcase
  endfunction

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

  // Does the pattern of this stage end on cur, given the byte window?
  function automatic bit tail_matches(input logic [7:0] cur, input logic [1:0] which);
    int         len;
    logic [7:0] got;
    logic [7:0] want;
    len = pat_len(which);
    if (int'(pkt_len) < len - 1) return 1'b0;
    for (int k = 0; k < len; k++) begin
      got  = (k == 0) ? cur : byte_hist[k-1];
      want = pat_from_end(which, k);
      // only the file name is compared case-blind
      if (which == STAGE_NAME) begin
        got  = lower_ascii(got);
        want = lower_ascii(want);
      end
      if (got != want) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the scanner by one accepted beat; a last beat owes one report.
  task automatic predict_report(input in_beat_t b);
    out_beat_t rep;
    if (b.first_byte) restart_packet();
    if (pkt_len < 4) head_word = {head_word[23:0], b.data_byte};
    if (!halted) begin
      if (b.data_byte == 8'h00) begin
        halted = 1'b1;
      end else if (stage_hit != STAGE_SIG && tail_matches(b.data_byte, stage_hit + 2'd1)) begin
        stage_hit = stage_hit + 2'd1;
        if (stage_hit == STAGE_SIG) halted = 1'b1;
      end
    end
    for (int i = HIST_LEN - 1; i > 0; i--) byte_hist[i] = byte_hist[i-1];
    byte_hist[0] = b.data_byte;
    if (pkt_len < SIG_LEN) pkt_len = pkt_len + 7'd1;

    if (b.last_byte) begin
      rep.command_kind  = KIND_OTHER;
      rep.stage_reached = STAGE_NONE;
      if (scan_on) begin
        if (pkt_len >= 4) begin
          case (head_word)
            LEAD_EHLO: rep.command_kind = KIND_EHLO;
            LEAD_MAIL: rep.command_kind = KIND_MAIL;
            LEAD_RCPT: rep.command_kind = KIND_RCPT;
            default:   rep.command_kind = KIND_OTHER;
          endcase
        end
        // command packets never report a scan stage
        if (rep.command_kind == KIND_OTHER) rep.stage_reached = stage_hit;
      end
      rep.virus_found = (rep.stage_reached == STAGE_SIG);
      report_q.push_back(rep);
      restart_packet();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver. A beat is predicted at the edge it is accepted. Between beats
  // it idles for a random gap unless in a calm stretch.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.payload <= '0;
      tx_gap        <= 0;
    end else begin
      if (in_if.valid && in_if.ready) predict_report(in_if.payload);
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap != 0) begin
          tx_gap      <= tx_gap - 1;
          in_if.valid <= 1'b0;
        end else if (tx_q.size() != 0 && !(tx_q[0].drain && report_q.size() != 0)) begin
          in_if.valid   <= 1'b1;
          in_if.payload <= tx_q[0].beat;
          void'(tx_q.pop_front());
          tx_gap <= tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Report monitor. Checks each accepted report against the oldest prediction,
  // then may hold ready low for a random stall unless in a calm stretch.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_stall     <= 0;
    end else begin
      rx_next = rx_stall;
      if (out_if.valid && out_if.ready) begin
        if (report_q.size() == 0) begin
          $error({"report beat with none expected: ",
                  "command_kind %0d stage_reached %0d virus_found %0d"},
                 out_if.payload.command_kind, out_if.payload.stage_reached,
                 out_if.payload.virus_found);
          errors++;
        end else begin
          if (out_if.payload.command_kind != report_q[0].command_kind) begin
            $error("command_kind: expected %0d, got %0d",
                   report_q[0].command_kind, out_if.payload.command_kind);
            errors++;
          end
          if (out_if.payload.stage_reached != report_q[0].stage_reached) begin
            $error("stage_reached: expected %0d, got %0d",
                   report_q[0].stage_reached, out_if.payload.stage_reached);
            errors++;
          end
          if (out_if.payload.virus_found != report_q[0].virus_found) begin
            $error("virus_found: expected %0d, got %0d",
                   report_q[0].virus_found, out_if.payload.virus_found);
            errors++;
          end
          void'(report_q.pop_front());
        end
        rx_next = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (rx_next != 0) begin
        out_if.ready <= 1'b0;
        rx_stall     <= rx_next - 1;
      end else begin
        out_if.ready <= 1'b1;
        rx_stall     <= 0;
      end
    end
  end

  // Calm stretches (no idling) come and go on each side independently.
  always @(posedge clk) begin
    if ($urandom_range(0, 249) == 0) tx_calm <= ~tx_calm;
    if ($urandom_range(0, 249) == 0) rx_calm <= ~rx_calm;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Queue one packet. restart_at puts a stray first mark mid-packet (-1: none).
  task automatic queue_packet(input logic [7:0] pkt [$], input bit mark_first,
                              input bit mark_last, input int restart_at, input bit drain);
    pend_beat_t pb;
    foreach (pkt[i]) begin
      pb.beat.data_byte  = pkt[i];
      pb.beat.first_byte = (i == 0) ? mark_first : (i == restart_at);
      pb.beat.last_byte  = mark_last && (i == pkt.size() - 1);
      pb.drain           = drain && (i == 0);
      tx_q.push_back(pb);
    end
    queued_bytes += pkt.size();
  endtask

  task automatic queue_text(input string s, input bit mark_first, input bit mark_last,
                            input int restart_at);
    logic [7:0] pkt [$];
    for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
    queue_packet(pkt, mark_first, mark_last, restart_at, 1'b0);
  endtask

  task automatic push_word(ref logic [7:0] pkt [$], input logic [31:0] w);
    for (int k = 3; k >= 0; k--) pkt.push_back(w[8*k +: 8]);
  endtask

  task automatic push_noise(ref logic [7:0] pkt [$], input int n, input int lo);
    for (int i = 0; i < n; i++) pkt.push_back(8'($urandom_range(lo, 255)));
  endtask

  // Append a stage pattern; the file name always gets random letter case, the
  // others rarely (which breaks their exact match). Sometimes one byte is hit.
  task automatic append_pattern(ref logic [7:0] pkt [$], input logic [1:0] which);
    int         len;
    int         flip;
    bit         mix;
    logic [7:0] c;
    len  = pat_len(which);
    flip = ($urandom_range(0, 11) == 0) ? int'($urandom_range(0, len - 1)) : -1;
    mix  = (which == STAGE_NAME) || ($urandom_range(0, 11) == 0);
    for (int i = 0; i < len; i++) begin
      c = pat_from_end(which, len - 1 - i);
      if (mix && lower_ascii(c) >= 8'h61 && lower_ascii(c) <= 8'h7A && $urandom_range(0, 1))
        c = c ^ 8'h20;
      if (i == flip) c = c ^ 8'($urandom_range(1, 255));
      pkt.push_back(c);
    end
  endtask

  task automatic build_packet(ref logic [7:0] pkt [$]);
    int         sel;
    logic [1:0] lead_pick;
    logic [31:0] lead_w;
    bit         swap;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      // command packet, sometimes one bit off
      lead_pick = 2'($urandom_range(0, 2));
      lead_w = (lead_pick == 0) ? LEAD_EHLO : (lead_pick == 1) ? LEAD_MAIL : LEAD_RCPT;
      if ($urandom_range(0, 3) == 0) lead_w = lead_w ^ (32'h1 << $urandom_range(0, 31));
      push_word(pkt, lead_w);
      push_noise(pkt, $urandom_range(0, 6), 0);
    end else if (sel < 5) begin
      push_noise(pkt, $urandom_range(1, 8), 0);
    end else begin
      // staged scan: header and file name (order sometimes swapped), then signature, with random filler between
      swap = ($urandom_range(0, 11) == 0);
      if ($urandom_range(0, 7) == 0) push_word(pkt, LEAD_EHLO);
      push_noise(pkt, $urandom_range(0, 5), 1);
      append_pattern(pkt, swap ? STAGE_NAME : STAGE_HDR);
      push_noise(pkt, $urandom_range(0, 4), 1);
      append_pattern(pkt, swap ? STAGE_HDR : STAGE_NAME);
      push_noise(pkt, $urandom_range(0, 4), 1);
      append_pattern(pkt, STAGE_SIG);
      if ($urandom_range(0, 3) != 0) push_noise(pkt, $urandom_range(1, 3), 0);
      if ($urandom_range(0, 9) == 0) pkt.insert($urandom_range(0, pkt.size()), 8'h00);
      if ($urandom_range(0, 9) == 0) begin
        sel = $urandom_range(1, pkt.size());
        while (pkt.size() > sel) void'(pkt.pop_back());
      end
    end
  endtask

  // Random packets until both the byte and the packet counts are met.
  task automatic run_random(input int n_items, input int min_pkts);
    logic [7:0] pkt [$];
    int         start;
    int         closed;
    int         pkts;
    bit         mark_last;
    int         restart_at;
    start  = queued_bytes;
    closed = 0;
    pkts   = 0;
    mark_last = 1'b1;
    while (queued_bytes - start < n_items || closed < min_pkts) begin
      pkt.delete();
      build_packet(pkt);
      restart_at = ($urandom_range(0, 19) == 0) ? int'($urandom_range(1, pkt.size())) : -1;
      mark_last  = ($urandom_range(0, 19) != 0);
      // the fourth packet of each phase always waits for the core to empty
      queue_packet(pkt, $urandom_range(0, 7) != 0, mark_last, restart_at,
                   pkts == 3 || $urandom_range(0, 14) == 0);
      pkts++;
      if (mark_last) closed++;
    end
    // close a dangling packet so the phase ends idle
    if (!mark_last) begin
      pkt.delete();
      pkt.push_back(8'h2E);
      queue_packet(pkt, 1'b0, 1'b1, -1, 1'b0);
    end
  endtask

  task automatic wait_idle();
    while (tx_q.size() != 0 || in_if.valid || report_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup then access; the register takes the data at the access edge.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SCAN_ENABLE) scan_on = val[0];
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    restart_packet();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // scan is off out of reset: a one-beat packet still reports, all zero
    queue_text("E", 1'b1, 1'b1, -1);
    wait_idle();

    write_reg(REG_SCAN_ENABLE, 32'd1);
    // directed: command words, short packet, zero in the lead, one-beat packets
    queue_text("EHLO", 1'b1, 1'b1, -1);
    queue_text("MAILx", 1'b1, 1'b1, -1);
    queue_text("RCPT", 1'b0, 1'b1, -1);     // no first mark after a closed packet
    queue_text("EHL", 1'b1, 1'b1, -1);      // too short to classify
    queue_packet('{8'h45, 8'h48, 8'h00, 8'h4F}, 1'b1, 1'b1, -1, 1'b0);
    queue_packet('{8'hFF}, 1'b1, 1'b1, -1, 1'b0);
    queue_packet('{8'h00}, 1'b1, 1'b1, -1, 1'b0);
    queue_text("xxEHLO", 1'b1, 1'b1, 2);    // first mark mid-packet restarts it
    wait_idle();

    // scan off: everything reports zero
    write_reg(REG_SCAN_ENABLE, 32'd0);
    run_random(150, 2);
    wait_idle();

    // main body with scan on
    write_reg(REG_SCAN_ENABLE, 32'hFFFF_FFFF);
    run_random(1150, 12);
    wait_idle();

    write_reg(REG_SCAN_ENABLE, 32'd0);
    run_random(30, 1);
    wait_idle();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
